/* hdl/hxd_pkg.sv */
package hxd_pkg;

   // tile edge length in pixels
   localparam int TILE_SIZE = 16;

   // result kinds
   localparam logic [1:0] KIND_FILL = 2'd0;
   localparam logic [1:0] KIND_RAW  = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // register indexes of the write port
   localparam logic [2:0] CSR_LEFT   = 3'd0;
   localparam logic [2:0] CSR_TOP    = 3'd1;
   localparam logic [2:0] CSR_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_PSIZE  = 3'd4;
   localparam logic [2:0] CSR_ENDIAN = 3'd5;

   // pixel size codes
   localparam logic [1:0] PSIZE_1 = 2'd0;
   localparam logic [1:0] PSIZE_2 = 2'd1;

   // decoder phase within a tile
   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_RAW      = 3'd1,
      PH_BG       = 3'd2,
      PH_FG       = 3'd3,
      PH_COUNT    = 3'd4,
      PH_SUBCOLOR = 3'd5,
      PH_SUBXY    = 3'd6,
      PH_SUBWH    = 3'd7
   } phase_type;

   // one result
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [4:0]  box_w;
      logic [4:0]  box_h;
      logic [31:0] color;
      logic        last;
   } rsp_type;

   // tile extent for a remaining length: at most one tile
   function automatic logic [4:0] tile_span(input logic [15:0] v);
      logic [4:0] r;
      if (v >= 16'(TILE_SIZE)) begin
         r = 5'(TILE_SIZE);
      end else begin
         r = v[4:0];
      end
      return r;
   endfunction

endpackage

/* hdl/hextile_tile_stream_decoder_top.sv */
// Hextile rectangle decoder. Takes the encoded bytes of one rectangle, one byte per
// request, walks its 16x16 tiles in raster order and emits fill boxes and raw pixels;
// the final result of a rectangle carries rsp_last, and a byte that ends the rectangle
// without drawing yields an end marker. A byte is taken every cycle while req_stall is
// low: it updates the tile walker and its result (at most one per byte) is registered
// into a two-entry result buffer that drives the rsp_ side. req_stall rises only
// while both buffer entries wait to be taken. Write the csr_ registers only while no
// request is in flight; a write to a defined index restarts the walk at the first tile.
module hextile_tile_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_pos_x,
   output logic [15:0] rsp_pos_y,
   output logic [4:0]  rsp_box_w,
   output logic [4:0]  rsp_box_h,
   output logic [31:0] rsp_color,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import hxd_pkg::*;

   // configuration
   logic [15:0] left_ff, left_in, top_ff, top_in;
   logic [15:0] width_ff, width_in, height_ff, height_in;
   logic [1:0]  psize_ff, psize_in;
   logic        big_end_ff, big_end_in;

   // tile walker and decoder state
   phase_type   phase_ff, phase_in;
   logic [15:0] tile_x_ff, tile_x_in, tile_y_ff, tile_y_in;
   logic [15:0] rem_w_ff, rem_w_in, rem_h_ff, rem_h_in;
   logic [4:0]  tile_w_ff, tile_w_in, tile_h_ff, tile_h_in;
   logic [4:2]  flags_ff, flags_in;
   logic [31:0] bg_ff, bg_in, fg_ff, fg_in, accum_ff, accum_in;
   logic [1:0]  byte_cnt_ff, byte_cnt_in;
   logic [7:0]  subs_left_ff, subs_left_in, sub_pos_ff, sub_pos_in;
   logic [3:0]  raw_col_ff, raw_col_in, raw_row_ff, raw_row_in;

   // result buffer
   rsp_type     buf_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;

   logic        accept, pop, push;
   rsp_type     res;
   logic        res_valid;
   logic [7:0]  b;
   logic [1:0]  last_byte;
   logic [31:0] acc_base, acc_new;
   logic        pix_done;
   logic        tile_end;
   logic [7:0]  subs_dec;
   logic        empty_rect;

   assign accept     = req_valid && !req_stall;
   assign pop        = rsp_valid && !rsp_stall;
   assign push       = accept && res_valid;
   assign b          = req_stream_byte;
   assign empty_rect = (width_ff == 16'd0) || (height_ff == 16'd0);
   assign subs_dec   = subs_left_ff - 8'd1;

   // pixel byte assembly
   always_comb begin
      case (psize_ff)
         PSIZE_1: last_byte = 2'd0;
         PSIZE_2: last_byte = 2'd1;
         default: last_byte = 2'd3;
      endcase
      acc_base = (byte_cnt_ff == 2'd0) ? 32'd0 : accum_ff;
      if (big_end_ff) begin
         acc_new = {acc_base[23:0], b};
      end else begin
         acc_new = acc_base | ({24'd0, b} << {byte_cnt_ff, 3'b000});
      end
      pix_done = (byte_cnt_ff >= last_byte);
   end

   // decode step, tile walk and configuration writes
   always_comb begin
      left_in      = left_ff;
      top_in       = top_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      psize_in     = psize_ff;
      big_end_in   = big_end_ff;
      phase_in     = phase_ff;
      tile_x_in    = tile_x_ff;
      tile_y_in    = tile_y_ff;
      rem_w_in     = rem_w_ff;
      rem_h_in     = rem_h_ff;
      tile_w_in    = tile_w_ff;
      tile_h_in    = tile_h_ff;
      flags_in     = flags_ff;
      bg_in        = bg_ff;
      fg_in        = fg_ff;
      accum_in     = accum_ff;
      byte_cnt_in  = byte_cnt_ff;
      subs_left_in = subs_left_ff;
      sub_pos_in   = sub_pos_ff;
      raw_col_in   = raw_col_ff;
      raw_row_in   = raw_row_ff;
      res          = '0;
      res_valid    = 1'b0;
      tile_end     = 1'b0;

      if (csr_write) begin
         case (csr_index)
            CSR_LEFT:   left_in    = csr_data;
            CSR_TOP:    top_in     = csr_data;
            CSR_WIDTH:  width_in   = csr_data;
            CSR_HEIGHT: height_in  = csr_data;
            CSR_PSIZE:  psize_in   = csr_data[1:0];
            CSR_ENDIAN: big_end_in = csr_data[0];
            default: ;
         endcase
         // restart the walk from the new settings
         if (csr_index <= CSR_ENDIAN) begin
            tile_x_in   = left_in;
            tile_y_in   = top_in;
            rem_w_in    = width_in;
            rem_h_in    = height_in;
            tile_w_in   = tile_span(width_in);
            tile_h_in   = tile_span(height_in);
            phase_in    = PH_HEADER;
            byte_cnt_in = 2'd0;
         end
      end else if (accept && empty_rect) begin
         res.kind  = KIND_END;
         res.last  = 1'b1;
         res_valid = 1'b1;
      end else if (accept) begin
         case (phase_ff)
            PH_RAW: begin
               accum_in    = acc_new;
               byte_cnt_in = pix_done ? 2'd0 : byte_cnt_ff + 2'd1;
               if (pix_done) begin
                  res.kind  = KIND_RAW;
                  res.pos_x = tile_x_ff + {12'd0, raw_col_ff};
                  res.pos_y = tile_y_ff + {12'd0, raw_row_ff};
                  res.box_w = 5'd1;
                  res.box_h = 5'd1;
                  res.color = acc_new;
                  res_valid = 1'b1;
                  if ({1'b0, raw_col_ff} == tile_w_ff - 5'd1) begin
                     raw_col_in = 4'd0;
                     if ({1'b0, raw_row_ff} == tile_h_ff - 5'd1) begin
                        tile_end = 1'b1;
                     end else begin
                        raw_row_in = raw_row_ff + 4'd1;
                     end
                  end else begin
                     raw_col_in = raw_col_ff + 4'd1;
                  end
               end
            end
            PH_BG: begin
               accum_in    = acc_new;
               byte_cnt_in = pix_done ? 2'd0 : byte_cnt_ff + 2'd1;
               if (pix_done) begin
                  bg_in     = acc_new;
                  res.kind  = KIND_FILL;
                  res.pos_x = tile_x_ff;
                  res.pos_y = tile_y_ff;
                  res.box_w = tile_w_ff;
                  res.box_h = tile_h_ff;
                  res.color = acc_new;
                  res_valid = 1'b1;
                  if (flags_ff[2]) begin
                     phase_in = PH_FG;
                  end else if (flags_ff[3]) begin
                     phase_in = PH_COUNT;
                  end else begin
                     tile_end = 1'b1;
                  end
               end
            end
            PH_FG: begin
               accum_in    = acc_new;
               byte_cnt_in = pix_done ? 2'd0 : byte_cnt_ff + 2'd1;
               if (pix_done) begin
                  fg_in = acc_new;
                  if (flags_ff[3]) begin
                     phase_in = PH_COUNT;
                  end else begin
                     tile_end = 1'b1;
                  end
               end
            end
            PH_COUNT: begin
               subs_left_in = b;
               if (b == 8'd0) begin
                  tile_end = 1'b1;
               end else begin
                  phase_in = flags_ff[4] ? PH_SUBCOLOR : PH_SUBXY;
               end
            end
            PH_SUBCOLOR: begin
               accum_in    = acc_new;
               byte_cnt_in = pix_done ? 2'd0 : byte_cnt_ff + 2'd1;
               if (pix_done) begin
                  phase_in = PH_SUBXY;
               end
            end
            PH_SUBXY: begin
               sub_pos_in = b;
               phase_in   = PH_SUBWH;
            end
            PH_SUBWH: begin
               res.kind     = KIND_FILL;
               res.pos_x    = tile_x_ff + {12'd0, sub_pos_ff[7:4]};
               res.pos_y    = tile_y_ff + {12'd0, sub_pos_ff[3:0]};
               res.box_w    = {1'b0, b[7:4]} + 5'd1;
               res.box_h    = {1'b0, b[3:0]} + 5'd1;
               res.color    = flags_ff[4] ? accum_ff : fg_ff;
               res_valid    = 1'b1;
               subs_left_in = subs_dec;
               if (subs_dec == 8'd0) begin
                  tile_end = 1'b1;
               end else begin
                  phase_in = flags_ff[4] ? PH_SUBCOLOR : PH_SUBXY;
               end
            end
            default: begin
               // subencoding byte
               flags_in    = b[4:2];
               byte_cnt_in = 2'd0;
               if (b[0]) begin
                  raw_col_in = 4'd0;
                  raw_row_in = 4'd0;
                  phase_in   = PH_RAW;
               end else if (b[1]) begin
                  phase_in = PH_BG;
               end else begin
                  res.kind  = KIND_FILL;
                  res.pos_x = tile_x_ff;
                  res.pos_y = tile_y_ff;
                  res.box_w = tile_w_ff;
                  res.box_h = tile_h_ff;
                  res.color = bg_ff;
                  res_valid = 1'b1;
                  if (b[2]) begin
                     phase_in = PH_FG;
                  end else if (b[3]) begin
                     phase_in = PH_COUNT;
                  end else begin
                     tile_end = 1'b1;
                  end
               end
            end
         endcase

         // advance to the next tile, or close the rectangle
         if (tile_end) begin
            phase_in    = PH_HEADER;
            byte_cnt_in = 2'd0;
            if (rem_w_ff > 16'(TILE_SIZE)) begin
               tile_x_in = tile_x_ff + 16'(TILE_SIZE);
               rem_w_in  = rem_w_ff - 16'(TILE_SIZE);
               tile_w_in = tile_span(rem_w_ff - 16'(TILE_SIZE));
            end else begin
               tile_x_in = left_ff;
               rem_w_in  = width_ff;
               tile_w_in = tile_span(width_ff);
               if (rem_h_ff > 16'(TILE_SIZE)) begin
                  tile_y_in = tile_y_ff + 16'(TILE_SIZE);
                  rem_h_in  = rem_h_ff - 16'(TILE_SIZE);
                  tile_h_in = tile_span(rem_h_ff - 16'(TILE_SIZE));
               end else begin
                  tile_y_in = top_ff;
                  rem_h_in  = height_ff;
                  tile_h_in = tile_span(height_ff);
                  if (!res_valid) begin
                     res       = '0;
                     res.kind  = KIND_END;
                     res_valid = 1'b1;
                  end
                  res.last = 1'b1;
               end
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= 16'd0;
         top_ff       <= 16'd0;
         width_ff     <= 16'd1;
         height_ff    <= 16'd1;
         psize_ff     <= 2'd2;
         big_end_ff   <= 1'b0;
         phase_ff     <= PH_HEADER;
         tile_x_ff    <= 16'd0;
         tile_y_ff    <= 16'd0;
         rem_w_ff     <= 16'd1;
         rem_h_ff     <= 16'd1;
         tile_w_ff    <= 5'd1;
         tile_h_ff    <= 5'd1;
         flags_ff     <= '0;
         bg_ff        <= 32'd0;
         fg_ff        <= 32'd0;
         accum_ff     <= 32'd0;
         byte_cnt_ff  <= 2'd0;
         subs_left_ff <= 8'd0;
         sub_pos_ff   <= 8'd0;
         raw_col_ff   <= 4'd0;
         raw_row_ff   <= 4'd0;
      end else begin
         left_ff      <= left_in;
         top_ff       <= top_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         psize_ff     <= psize_in;
         big_end_ff   <= big_end_in;
         phase_ff     <= phase_in;
         tile_x_ff    <= tile_x_in;
         tile_y_ff    <= tile_y_in;
         rem_w_ff     <= rem_w_in;
         rem_h_ff     <= rem_h_in;
         tile_w_ff    <= tile_w_in;
         tile_h_ff    <= tile_h_in;
         flags_ff     <= flags_in;
         bg_ff        <= bg_in;
         fg_ff        <= fg_in;
         accum_ff     <= accum_in;
         byte_cnt_ff  <= byte_cnt_in;
         subs_left_ff <= subs_left_in;
         sub_pos_ff   <= sub_pos_in;
         raw_col_ff   <= raw_col_in;
         raw_row_ff   <= raw_row_in;
      end
   end

   // two-entry result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // result buffer payload
   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= res;
      end
   end

   assign req_stall = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_kind  = buf_ff[rd_ptr_ff].kind;
   assign rsp_pos_x = buf_ff[rd_ptr_ff].pos_x;
   assign rsp_pos_y = buf_ff[rd_ptr_ff].pos_y;
   assign rsp_box_w = buf_ff[rd_ptr_ff].box_w;
   assign rsp_box_h = buf_ff[rd_ptr_ff].box_h;
   assign rsp_color = buf_ff[rd_ptr_ff].color;
   assign rsp_last  = buf_ff[rd_ptr_ff].last;

endmodule

/* hdl/hxd_checker.sv */
module hxd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_pos_x,
   input logic [15:0] rsp_pos_y,
   input logic [4:0]  rsp_box_w,
   input logic [4:0]  rsp_box_h,
   input logic [31:0] rsp_color,
   input logic        rsp_last
);
   import hxd_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_pos_x)
         && $stable(rsp_pos_y) && $stable(rsp_box_w) && $stable(rsp_box_h)
         && $stable(rsp_color) && $stable(rsp_last))
      else $error("stalled result changed");

   // requests stall only while results wait to be taken
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result waiting");

   // end marker closes the rectangle and carries no drawing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_END |-> rsp_last && rsp_pos_x == 16'd0
         && rsp_pos_y == 16'd0 && rsp_box_w == 5'd0 && rsp_box_h == 5'd0
         && rsp_color == 32'd0)
      else $error("malformed end marker");

   // raw pixel is a single 1x1 box
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_RAW |-> rsp_box_w == 5'd1 && rsp_box_h == 5'd1)
      else $error("raw pixel with box size other than one");

   // fill box sizes lie in one to sixteen
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FILL |-> rsp_box_w != 5'd0 && rsp_box_h != 5'd0
         && rsp_box_w <= 5'd16 && rsp_box_h <= 5'd16)
      else $error("fill box size out of range");

endmodule

bind hextile_tile_stream_decoder_top hxd_checker u_hxd_checker (.*);
